// ----- src/tdfr_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tdfr_pkg: shared types and constants of the timed DAC frame renderer.
// Holds the command codes, controller states, register indexes and the
// command and status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package tdfr_pkg;

    localparam int CMD_W      = 2;
    localparam int CHAN_W     = 2;
    localparam int DATA_W     = 8;
    localparam int CYC_W      = 24;
    localparam int IDX_W      = 10;
    localparam int SAMPLE_W   = 8;
    localparam int FLEN_W     = 11;
    localparam int CFG_ADDR_W = 1;

    localparam logic [FLEN_W-1:0]     FRAME_LEN_RST  = 11'd735;
    localparam logic                  OUTPUT_EN_RST  = 1'b1;
    localparam logic [DATA_W-1:0]     AMP_OFFSET     = 8'h80;

    localparam logic [CFG_ADDR_W-1:0] REG_FRAME_LEN  = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] REG_OUTPUT_EN  = 1'b1;

    typedef enum logic [CMD_W-1:0] {
        CMD_WRITE     = 2'd0,
        CMD_FRAME_END = 2'd1,
        CMD_READ      = 2'd2
    } t_cmd_e;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL,
        S_DINIT,
        S_DIV,
        S_WSETUP,
        S_WFILL,
        S_FSETUP,
        S_FFILL,
        S_RD,
        S_RDOUT
    } t_state_e;

    // Controller to datapath.
    typedef struct packed {
        logic load;        // capture the accepted beat
        logic mul;         // form frame_len * (period - left)
        logic div_init;    // seed the divider from the product
        logic div_step;    // one quotient bit
        logic wr_setup;    // fill range of a data write
        logic fe_setup;    // fill range of a frame end, current channel
        logic fill_step;   // one sample write, if any remain
        logic wr_commit;   // store fill position and new held amplitude
        logic fe_done;     // rewind channel and advance to the next one
    } t_dp_cmd;

    // Datapath to controller.
    typedef struct packed {
        logic ch_ok;       // addressed channel exists
        logic div_last;    // last quotient bit is being formed
        logic fill_done;   // fill pointer reached its target
        logic ch_last;     // frame end is on the last channel
    } t_dp_status;

endpackage : tdfr_pkg
`default_nettype wire

// ----- src/tdfr_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tdfr_ctrl: command sequencer of the timed DAC frame renderer.
// Walks each accepted beat through multiply, divide, fill or read steps.
// ----------------------------------------------------------------------------
module tdfr_ctrl
    import tdfr_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    input  wire logic [CMD_W-1:0]  i_in_cmd,
    input  wire logic              i_output_en,
    input  wire logic              i_out_free,
    input  wire t_dp_status        i_status,
    output t_dp_cmd                o_cmd,
    output logic                   o_in_ready,
    output logic                   o_out_load
);

    t_state_e r_state;
    t_state_e n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    case (i_in_cmd)
                        CMD_WRITE:     n_state = S_MUL;
                        CMD_FRAME_END: n_state = i_output_en ? S_FSETUP : S_IDLE;
                        CMD_READ:      n_state = S_RD;
                        default:       n_state = S_IDLE;
                    endcase
                end
            end
            S_MUL:    n_state = i_status.ch_ok ? S_DINIT : S_IDLE;
            S_DINIT:  n_state = S_DIV;
            S_DIV:    n_state = i_status.div_last ? S_WSETUP : S_DIV;
            S_WSETUP: n_state = S_WFILL;
            S_WFILL:  n_state = i_status.fill_done ? S_IDLE : S_WFILL;
            S_FSETUP: n_state = S_FFILL;
            S_FFILL: begin
                if (i_status.fill_done) begin
                    n_state = i_status.ch_last ? S_IDLE : S_FSETUP;
                end
            end
            S_RD:     n_state = S_RDOUT;
            S_RDOUT:  n_state = i_out_free ? S_IDLE : S_RDOUT;
            default:  n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        o_out_load = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            S_MUL:    o_cmd.mul      = 1'b1;
            S_DINIT:  o_cmd.div_init = 1'b1;
            S_DIV:    o_cmd.div_step = 1'b1;
            S_WSETUP: o_cmd.wr_setup = 1'b1;
            S_WFILL: begin
                o_cmd.fill_step = 1'b1;
                o_cmd.wr_commit = i_status.fill_done;
            end
            S_FSETUP: o_cmd.fe_setup = 1'b1;
            S_FFILL: begin
                o_cmd.fill_step = 1'b1;
                o_cmd.fe_done   = i_status.fill_done;
            end
            S_RD:     o_cmd = '0;
            S_RDOUT:  o_out_load = i_out_free;
            default:  o_cmd = '0;
        endcase
    end

endmodule : tdfr_ctrl
`default_nettype wire

// ----- src/tdfr_datapath.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tdfr_datapath: arithmetic, per-channel state and sample memory.
// Holds the multiplier, the restoring divider, the fill pointer, the fill
// positions and held amplitudes, and the frame sample memory.
// ----------------------------------------------------------------------------
module tdfr_datapath
    import tdfr_pkg::*;
#(
    parameter int CHANNELS      = 4,
    parameter int FRAME_LEN_MAX = 1024
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire t_dp_cmd             i_cmd,
    input  wire logic [CMD_W-1:0]    i_in_cmd,
    input  wire logic [CHAN_W-1:0]   i_in_ch,
    input  wire logic [DATA_W-1:0]   i_in_data,
    input  wire logic [CYC_W-1:0]    i_in_period,
    input  wire logic [CYC_W-1:0]    i_in_left,
    input  wire logic [IDX_W-1:0]    i_in_idx,
    input  wire logic [FLEN_W-1:0]   i_frame_len,
    output t_dp_status               o_status,
    output logic [SAMPLE_W-1:0]      o_rd_sample,
    output logic [CHAN_W-1:0]        o_rd_channel
);

    localparam int CH_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int POS_W   = $clog2(FRAME_LEN_MAX);
    localparam int PTR_W   = POS_W + 1;
    localparam int PROD_W  = PTR_W + CYC_W;
    localparam int DCNT_W  = $clog2(PTR_W + 1);
    localparam int ADDR_W  = CH_W + POS_W;
    localparam int MEM_DEP = 1 << ADDR_W;

    logic [CH_W-1:0]     r_ch;
    logic                r_ch_ok;
    logic [CHAN_W-1:0]   r_ch_in;
    logic [DATA_W-1:0]   r_data;
    logic [CYC_W-1:0]    r_period;
    logic [CYC_W-1:0]    r_diff;
    logic                r_zero;
    logic [IDX_W-1:0]    r_idx;
    logic [PTR_W-1:0]    r_len;
    logic [PROD_W-1:0]   r_prod;
    logic [CYC_W-1:0]    r_rem;
    logic [PTR_W-1:0]    r_lo;
    logic [PTR_W-1:0]    r_q;
    logic [DCNT_W-1:0]   r_dcnt;
    logic [PTR_W-1:0]    r_p;
    logic [PTR_W-1:0]    r_upto;
    logic [POS_W-1:0]    r_fpos [CHANNELS];
    logic [DATA_W-1:0]   r_held [CHANNELS];
    logic [SAMPLE_W-1:0] r_mem  [MEM_DEP];
    logic [SAMPLE_W-1:0] r_rd_data;

    logic [PTR_W-1:0]    eff_len;
    logic [CYC_W:0]      trial;
    logic [CYC_W:0]      trial_sub;
    logic [PTR_W-1:0]    wr_pos;
    logic                fill_done;
    logic                rd_ok;

    // Frame length held within 1..FRAME_LEN_MAX.
    always_comb begin
        if (i_frame_len == '0) begin
            eff_len = PTR_W'(1);
        end else if (32'(i_frame_len) > FRAME_LEN_MAX) begin
            eff_len = PTR_W'(FRAME_LEN_MAX);
        end else begin
            eff_len = PTR_W'(i_frame_len);
        end
    end

    assign trial     = {r_rem, r_lo[PTR_W-1]};
    assign trial_sub = trial - {1'b0, r_period};

    // Write position clamped to the last sample of the frame, or 0 when r_zero is set.
    always_comb begin
        if (r_zero) begin
            wr_pos = '0;
        end else if (r_q >= r_len) begin
            wr_pos = r_len - PTR_W'(1);
        end else begin
            wr_pos = r_q;
        end
    end

    assign fill_done = (r_p >= r_upto);
    assign rd_ok     = r_ch_ok && (16'(r_idx) < 16'(r_len));

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_ch     <= (i_in_cmd == CMD_FRAME_END) ? '0 : CH_W'(i_in_ch);
            r_ch_ok  <= (32'(i_in_ch) < CHANNELS);
            r_ch_in  <= i_in_ch;
            r_data   <= i_in_data;
            r_period <= i_in_period;
            r_diff   <= i_in_period - i_in_left;
            r_zero   <= (i_in_period == '0) || (i_in_left > i_in_period);
            r_idx    <= i_in_idx;
            r_len    <= eff_len;
        end
        if (i_cmd.mul) begin
            r_prod <= PROD_W'(r_len) * PROD_W'(r_diff);
        end
        if (i_cmd.div_init) begin
            r_rem  <= r_prod[PROD_W-1:PTR_W];
            r_lo   <= r_prod[PTR_W-1:0];
            r_q    <= '0;
            r_dcnt <= '0;
        end
        if (i_cmd.div_step) begin
            if (!trial_sub[CYC_W]) begin
                r_rem <= trial_sub[CYC_W-1:0];
            end else begin
                r_rem <= trial[CYC_W-1:0];
            end
            r_lo   <= r_lo << 1;
            r_q    <= {r_q[PTR_W-2:0], ~trial_sub[CYC_W]};
            r_dcnt <= r_dcnt + DCNT_W'(1);
        end
        if (i_cmd.wr_setup) begin
            r_upto <= wr_pos;
            r_p    <= PTR_W'(r_fpos[r_ch]);
        end
        if (i_cmd.fe_setup) begin
            r_upto <= r_len;
            r_p    <= PTR_W'(r_fpos[r_ch]);
        end
        if (i_cmd.fill_step && !fill_done) begin
            r_p <= r_p + PTR_W'(1);
        end
        if (i_cmd.fe_done) begin
            r_ch <= r_ch + CH_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CHANNELS; i++) begin
                r_fpos[i] <= '0;
                r_held[i] <= '0;
            end
        end else begin
            if (i_cmd.wr_commit) begin
                r_fpos[r_ch] <= r_p[POS_W-1:0];
                r_held[r_ch] <= r_data ^ AMP_OFFSET;
            end
            if (i_cmd.fe_done) begin
                r_fpos[r_ch] <= '0;
            end
        end
    end

    // One write port for the fill, one registered read port for sample reads.
    always_ff @(posedge i_clk) begin
        if (i_cmd.fill_step && !fill_done) begin
            r_mem[{r_ch, r_p[POS_W-1:0]}] <= r_held[r_ch];
        end
        r_rd_data <= r_mem[{r_ch, POS_W'(r_idx)}];
    end

    assign o_status.ch_ok     = r_ch_ok;
    assign o_status.div_last  = (r_dcnt == DCNT_W'(PTR_W - 1));
    assign o_status.fill_done = fill_done;
    assign o_status.ch_last   = (r_ch == CH_W'(CHANNELS - 1));

    assign o_rd_sample  = rd_ok ? r_rd_data : '0;
    assign o_rd_channel = r_ch_in;

endmodule : tdfr_datapath
`default_nettype wire

// ----- src/timed_dac_frame_renderer_unit.sv -----
// One beat at a time. A read passes S_RD and S_RDOUT, waiting there for a free
// result slot; its result beat appears in the same cycle as the input is ready
// again. A data write runs the multiply, the divider seed, the bit-per-cycle
// divider, the fill setup and the fill. With output enabled, a frame end runs a
// fill setup and a fill per channel. Synchronous active-low reset clears control,
// config, channel and output-valid state; not the sample memory or beat registers.
`default_nettype none
// ----------------------------------------------------------------------------
// timed_dac_frame_renderer_unit: zero-order-hold DAC frame buffer renderer.
// Renders timed 8-bit DAC writes into per-channel sample frames and returns
// stored samples on request.
// ----------------------------------------------------------------------------
module timed_dac_frame_renderer_unit
    import tdfr_pkg::*;
#(
    parameter int CHANNELS      = 4,
    parameter int FRAME_LEN_MAX = 1024
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // Configuration write port.
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  wire logic [FLEN_W-1:0]     i_cfg_wdata,
    // Input stream.
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    // tdata, from bit 0: channel_num[1:0], data_value[9:2], period_cycles[33:10],
    // cycles_left[57:34], sample_index[67:58], zero pad[71:68].
    input  wire logic [71:0]           s_axis_tdata,
    // tuser: cmd[1:0].
    input  wire logic [CMD_W-1:0]      s_axis_tuser,
    // Output stream.
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // tdata, from bit 0: sample_value[7:0], sample_channel[9:8], zero pad[15:10].
    output logic [15:0]                m_axis_tdata
);

    logic [FLEN_W-1:0]   r_frame_len;
    logic                r_output_en;
    logic                r_out_valid;
    logic [SAMPLE_W-1:0] r_out_sample;
    logic [CHAN_W-1:0]   r_out_channel;

    t_dp_cmd             dp_cmd;
    t_dp_status          dp_status;
    logic                in_ready;
    logic                out_load;
    logic                out_free;
    logic [SAMPLE_W-1:0] rd_sample;
    logic [CHAN_W-1:0]   rd_channel;

    // Configuration registers. Write only while the block is idle (not enforced).
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_len <= FRAME_LEN_RST;
            r_output_en <= OUTPUT_EN_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                REG_FRAME_LEN: r_frame_len <= i_cfg_wdata;
                REG_OUTPUT_EN: r_output_en <= i_cfg_wdata[0];
                default:       r_frame_len <= r_frame_len;
            endcase
        end
    end

    // The result beat sits in its own register, so the sequencer is free to
    // take the next input beat while the consumer stalls. A new result only
    // enters once the slot is empty or being drained in the same cycle.
    assign out_free = !r_out_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_sample  <= rd_sample;
            r_out_channel <= rd_channel;
        end
    end

    tdfr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_in_cmd    (s_axis_tuser),
        .i_output_en (r_output_en),
        .i_out_free  (out_free),
        .i_status    (dp_status),
        .o_cmd       (dp_cmd),
        .o_in_ready  (in_ready),
        .o_out_load  (out_load)
    );

    tdfr_datapath #(
        .CHANNELS      (CHANNELS),
        .FRAME_LEN_MAX (FRAME_LEN_MAX)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (dp_cmd),
        .i_in_cmd     (s_axis_tuser),
        .i_in_ch      (s_axis_tdata[1:0]),
        .i_in_data    (s_axis_tdata[9:2]),
        .i_in_period  (s_axis_tdata[33:10]),
        .i_in_left    (s_axis_tdata[57:34]),
        .i_in_idx     (s_axis_tdata[67:58]),
        .i_frame_len  (r_frame_len),
        .o_status     (dp_status),
        .o_rd_sample  (rd_sample),
        .o_rd_channel (rd_channel)
    );

    // No input beat is taken while reset is held.
    assign s_axis_tready = in_ready && i_rst_n;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {6'b0, r_out_channel, r_out_sample};

endmodule : timed_dac_frame_renderer_unit
`default_nettype wire

// ----- tb/tb_timed_dac_frame_renderer_unit.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_timed_dac_frame_renderer_unit: self-checking bench for the DAC renderer.
// Timed DAC writes, frame ends and sample reads are sent on the input stream.
// A zero-order-hold frame model in the bench tracks every channel buffer and
// predicts each read beat. The checker compares every output beat with the
// oldest predicted read. Both stream sides idle at random, and one phase holds
// the output off long enough for the block to stall its input.
// ----------------------------------------------------------------------------
module tb_timed_dac_frame_renderer_unit;
    import tdfr_pkg::*;

    localparam int NUM_CH      = 4;
    localparam int FRAME_MAX   = 1024;
    // Quiet cycles allowed before the run is declared hung. The slowest gap is
    // a full frame end at the largest length followed by a settle pause.
    localparam int QUIET_LIMIT = 40000;
    // Length of the long output hold-off in the back-pressure phase.
    localparam int HOLD_CYCLES = 400;
    // The command code that the block must ignore.
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    // One read answer: the sample and the channel it came from.
    typedef struct packed {
        logic [CHAN_W-1:0]   chan;
        logic [SAMPLE_W-1:0] value;
    } t_sample_beat;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_ADDR_W-1:0] i_cfg_addr;
    logic [FLEN_W-1:0]     i_cfg_wdata;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    // tdata, from bit 0: channel_num, data_value, period_cycles, cycles_left,
    // sample_index, zero pad.
    logic [71:0]           s_axis_tdata;
    // tuser: cmd.
    logic [CMD_W-1:0]      s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    // tdata, from bit 0: sample_value, sample_channel, zero pad.
    logic [15:0]           m_axis_tdata;

    // Frame model state. The bench keeps its own copy of the sample buffers,
    // the fill positions, the held amplitudes and both registers.
    logic [SAMPLE_W-1:0] frame_store [NUM_CH][FRAME_MAX];
    bit                  filled_map  [NUM_CH][FRAME_MAX];
    logic [IDX_W-1:0]    fill_pos    [NUM_CH];
    logic [DATA_W-1:0]   held_amp    [NUM_CH];
    logic [FLEN_W-1:0]   cfg_frame_len;
    logic                cfg_out_en;

    // Read answers that are still on their way out of the block.
    t_sample_beat pending_reads [$];
    int           mismatch_count = 0;

    // Test controls seen by the ready driver. A toggle of hold_toggle starts
    // one long hold-off; no_idle removes all random gaps on both sides.
    bit hold_toggle = 1'b0;
    bit no_idle     = 1'b0;

    timed_dac_frame_renderer_unit #(
        .CHANNELS      (NUM_CH),
        .FRAME_LEN_MAX (FRAME_MAX)
    ) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Frame model
    // ------------------------------------------------------------------

    // The frame length in use: the register held within 1 to FRAME_MAX.
    function automatic int unsigned eff_len();
        if (cfg_frame_len == 0) return 1;
        if (cfg_frame_len > FRAME_MAX) return FRAME_MAX;
        return cfg_frame_len;
    endfunction

    // Cycles the block may still be busy after its last beat: a frame end at
    // the current length, with margin.
    function automatic int settle_cycles();
        return 4 * (eff_len() + 2) + 64;
    endfunction

    // Zero-order hold: the channel keeps its held amplitude from its fill
    // position up to the given point. A point behind the fill position fills
    // nothing and leaves the position alone.
    function automatic void hold_fill(input int ch, input int unsigned upto);
        int unsigned p;
        p = fill_pos[ch];
        while (p < upto) begin
            frame_store[ch][p] = held_amp[ch];
            filled_map[ch][p]  = 1'b1;
            p++;
        end
        fill_pos[ch] = p[IDX_W-1:0];
    endfunction

    // Applies one accepted input beat to the frame model and queues the answer
    // of a read.
    function automatic void render_beat(input logic [CMD_W-1:0]  cmd,
                                        input logic [CHAN_W-1:0] ch,
                                        input logic [DATA_W-1:0] data,
                                        input logic [CYC_W-1:0]  period,
                                        input logic [CYC_W-1:0]  left,
                                        input logic [IDX_W-1:0]  idx);
        int unsigned  len;
        logic [63:0]  pos;
        t_sample_beat ans;
        int           c;
        len = eff_len();
        if (cmd == CMD_WRITE) begin
            // Position in the frame from the elapsed part of the period. A zero
            // period or more cycles left than the period lands on sample 0.
            pos = '0;
            if (period != 0 && left <= period) begin
                pos = (64'(len) * (64'(period) - 64'(left))) / 64'(period);
                if (pos >= 64'(len)) pos = 64'(len - 1);
            end
            hold_fill(int'(ch), pos[31:0]);
            held_amp[ch] = data - AMP_OFFSET;
        end else if (cmd == CMD_FRAME_END) begin
            // With output disabled the frame end leaves everything as it is.
            if (cfg_out_en) begin
                for (c = 0; c < NUM_CH; c++) begin
                    hold_fill(c, len);
                    fill_pos[c] = '0;
                end
            end
        end else if (cmd == CMD_READ) begin
            ans.chan  = ch;
            ans.value = (idx < len) ? frame_store[ch][idx] : '0;
            pending_reads.push_back(ans);
        end
    endfunction

    // Chooses a read index that never touches a sample that was never filled:
    // either a filled position inside the frame or a position beyond it.
    // Returns -1 when the frame fills the whole buffer and eight tries find no filled position.
    function automatic int pick_read_index(input logic [CHAN_W-1:0] ch);
        int unsigned len;
        int          cand;
        int          k;
        len = eff_len();
        if (len < FRAME_MAX && $urandom_range(0, 5) == 0)
            return $urandom_range(len, FRAME_MAX - 1);
        for (k = 0; k < 8; k++) begin
            cand = $urandom_range(0, len - 1);
            if (filled_map[ch][cand]) return cand;
        end
        if (len < FRAME_MAX) return $urandom_range(len, FRAME_MAX - 1);
        return -1;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Sender idle gap: mostly none or short, now and then a long one.
    function automatic int pick_gap();
        int r;
        if (no_idle) return 0;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 95) return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    // A frame period of random bit width, so that small and large periods
    // both occur and every period bit toggles.
    function automatic int unsigned rand_period();
        int unsigned w;
        w = $urandom_range(1, CYC_W);
        return $urandom_range(1, (1 << w) - 1);
    endfunction

    // Offers one beat and waits until it is accepted. On return tvalid is
    // still high with the accepted beat, so the next call in the same time
    // step either replaces it or lowers tvalid, never both.
    task automatic send_beat(input logic [CMD_W-1:0]  cmd,
                             input logic [CHAN_W-1:0] ch,
                             input logic [DATA_W-1:0] data,
                             input logic [CYC_W-1:0]  period,
                             input logic [CYC_W-1:0]  left,
                             input logic [IDX_W-1:0]  idx);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {4'b0, idx, left, period, data, ch};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        render_beat(cmd, ch, data, period, left, idx);
    endtask

    task automatic send_write(input logic [CHAN_W-1:0] ch, input logic [DATA_W-1:0] data,
                              input logic [CYC_W-1:0] period, input logic [CYC_W-1:0] left);
        send_beat(CMD_WRITE, ch, data, period, left, IDX_W'($urandom));
    endtask

    task automatic send_frame_end();
        send_beat(CMD_FRAME_END, CHAN_W'($urandom), DATA_W'($urandom), CYC_W'($urandom),
                  CYC_W'($urandom), IDX_W'($urandom));
    endtask

    task automatic send_read(input logic [CHAN_W-1:0] ch, input logic [IDX_W-1:0] idx);
        send_beat(CMD_READ, ch, DATA_W'($urandom), CYC_W'($urandom), CYC_W'($urandom), idx);
    endtask

    // Brings the block to rest: lowers tvalid, waits for every read answer and
    // then lets a frame end's worth of cycles pass, since writes and frame ends
    // give no beat that would show when they are done.
    task automatic quiesce();
        s_axis_tvalid <= 1'b0;
        while (pending_reads.size() != 0) @(posedge i_clk);
        repeat (settle_cycles()) @(posedge i_clk);
    endtask

    // One register write. Only called while the block is at rest.
    task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr,
                             input logic [FLEN_W-1:0]     value);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= addr;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        @(posedge i_clk);
        if (addr == REG_FRAME_LEN) cfg_frame_len = value;
        else cfg_out_en = value[0];
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Directed beats on the reset configuration: extreme fields, the zero
    // period, more cycles left than the period, a write behind the fill point,
    // the unused command, reads inside and beyond the frame, and a frame end.
    task automatic test_reset_defaults();
        int unsigned len;
        len = eff_len();
        // Full period left lands on sample 0, so nothing is filled yet.
        send_write(2'd0, 8'h00, 24'hFFFFFF, 24'hFFFFFF);
        // No cycles left clamps to the last sample and fills up to it.
        send_write(2'd0, 8'hFF, 24'hFFFFFF, 24'h000000);
        send_read(2'd0, 10'd0);
        send_read(2'd0, IDX_W'(len - 2));
        send_read(2'd0, 10'h3FF);
        // A zero period fills nothing but still takes the new amplitude.
        send_write(2'd1, 8'hA5, 24'd0, 24'd0);
        // More cycles left than the period also lands on sample 0.
        send_write(2'd2, 8'h80, 24'd1000, 24'd2000);
        // This position is behind channel 0's fill point: nothing moves.
        send_write(2'd0, 8'h01, 24'd1000, 24'd500);
        send_beat(CMD_UNUSED, 2'd3, 8'hFF, 24'hFFFFFF, 24'hFFFFFF, 10'h3FF);
        send_frame_end();
        send_read(2'd0, IDX_W'(len - 1));
        send_read(2'd1, 10'd0);
        send_read(2'd2, 10'd500);
        send_read(2'd3, IDX_W'(len - 1));
    endtask

    // With output disabled a frame end must neither fill nor rewind, so the
    // second write carries on from where the first one stopped.
    task automatic test_output_disabled();
        quiesce();
        write_reg(REG_OUTPUT_EN, 11'd0);
        send_write(2'd3, 8'h7F, 24'd100, 24'd50);
        send_frame_end();
        send_write(2'd3, 8'h00, 24'd100, 24'd0);
        send_read(2'd3, 10'd400);
        quiesce();
        write_reg(REG_OUTPUT_EN, 11'd1);
        send_frame_end();
        send_read(2'd3, IDX_W'(eff_len() - 1));
    endtask

    // Frame lengths of zero and beyond the buffer are held to 1 and to the
    // buffer size; a length of 1 is the smallest legal frame.
    task automatic test_frame_len_limits();
        logic [FLEN_W-1:0] lens [3];
        int                k;
        lens = '{11'd0, 11'd2047, 11'd1};
        for (k = 0; k < 3; k++) begin
            quiesce();
            write_reg(REG_FRAME_LEN, lens[k]);
            send_write(CHAN_W'($urandom), DATA_W'($urandom), 24'hFFFFFF, 24'd0);
            send_frame_end();
            send_read(CHAN_W'($urandom), IDX_W'(eff_len() - 1));
        end
    endtask

    // Random frames. Most writes of a frame move forward in time on one period,
    // as a CPU would issue them; the rest are noise: random cycles left, a zero
    // period, or more cycles left than the period. Reads are mixed in, and most
    // frames close with a frame end.
    task automatic test_random_frames(input int n_items, input int unsigned len,
                                      input logic out_en, input bit quiet);
        int unsigned       period;
        int unsigned       left;
        int unsigned       stride;
        int                nwr;
        int                w;
        int                r;
        int                idx;
        int                sent;
        logic [CHAN_W-1:0] ch;
        logic [DATA_W-1:0] data;
        quiesce();
        write_reg(REG_FRAME_LEN, FLEN_W'(len));
        write_reg(REG_OUTPUT_EN, {10'd0, out_en});
        no_idle = quiet;
        sent = 0;
        while (sent < n_items) begin
            period = rand_period();
            left   = period;
            nwr    = $urandom_range(1, 12);
            for (w = 0; w < nwr && sent < n_items; w++) begin
                ch   = CHAN_W'($urandom);
                data = DATA_W'($urandom);
                r    = $urandom_range(0, 99);
                if (r < 78) begin
                    stride = $urandom_range(0, period / nwr + 1);
                    left   = (left > stride) ? left - stride : 0;
                    send_write(ch, data, CYC_W'(period), CYC_W'(left));
                end else if (r < 88) begin
                    send_write(ch, data, CYC_W'(period), CYC_W'($urandom));
                end else if (r < 94) begin
                    send_write(ch, data, 24'd0, CYC_W'($urandom));
                end else if (period < 24'hFFFFFF) begin
                    send_write(ch, data, CYC_W'(period),
                               CYC_W'($urandom_range(period + 1, 24'hFFFFFF)));
                end else begin
                    send_write(ch, data, CYC_W'(period), CYC_W'($urandom));
                end
                sent++;
                if ($urandom_range(0, 99) < 30) begin
                    ch  = CHAN_W'($urandom);
                    idx = pick_read_index(ch);
                    if (idx >= 0) begin
                        send_read(ch, IDX_W'(idx));
                        sent++;
                    end
                end
                if ($urandom_range(0, 99) < 3)
                    send_beat(CMD_UNUSED, CHAN_W'($urandom), DATA_W'($urandom),
                              CYC_W'($urandom), CYC_W'($urandom), IDX_W'($urandom));
            end
            if ($urandom_range(0, 9) != 0 && sent < n_items) begin
                send_frame_end();
                sent++;
            end
            repeat ($urandom_range(0, 4)) begin
                ch  = CHAN_W'($urandom);
                idx = pick_read_index(ch);
                if (idx >= 0 && sent < n_items) begin
                    send_read(ch, IDX_W'(idx));
                    sent++;
                end
            end
        end
        no_idle = 1'b0;
    endtask

    // The receiver holds off for a long stretch while reads keep coming back
    // to back, so the output beat backs up and the input must stall.
    task automatic test_read_backpressure();
        int                sent;
        int                idx;
        logic [CHAN_W-1:0] ch;
        no_idle = 1'b1;
        hold_toggle <= ~hold_toggle;
        sent = 0;
        while (sent < 24) begin
            ch  = CHAN_W'($urandom);
            idx = pick_read_index(ch);
            if (idx >= 0) begin
                send_read(ch, IDX_W'(idx));
                sent++;
            end
        end
        no_idle = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Output side
    // ------------------------------------------------------------------

    // Ready driver. Ready and stalled stretches alternate, stalls mostly short
    // and now and then long. A toggle of hold_toggle starts a long hold-off
    // that this process counts down itself.
    initial begin : rx_ready_driver
        int run_left;
        int hold_left;
        bit stalled;
        bit seen_toggle;
        run_left    = 0;
        hold_left   = 0;
        stalled     = 1'b0;
        seen_toggle = 1'b0;
        m_axis_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_toggle != seen_toggle) begin
                seen_toggle = hold_toggle;
                hold_left   = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else if (no_idle) begin
                m_axis_tready <= 1'b1;
            end else begin
                if (run_left == 0) begin
                    stalled = !stalled;
                    if (!stalled) run_left = $urandom_range(1, 24);
                    else if ($urandom_range(0, 99) < 85) run_left = $urandom_range(1, 3);
                    else run_left = $urandom_range(10, 60);
                end
                run_left--;
                m_axis_tready <= !stalled;
            end
        end
    end

    task automatic note_failure(input string msg);
        mismatch_count++;
        if (mismatch_count <= 10) $display("%s", msg);
    endtask

    // Every accepted output beat is matched against the oldest pending read.
    always @(posedge i_clk) begin : sample_checker
        t_sample_beat want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_reads.size() == 0) begin
                note_failure($sformatf("Sample beat with no read pending: ch %0d value %0d",
                                       m_axis_tdata[9:8], $signed(m_axis_tdata[7:0])));
            end else begin
                want = pending_reads.pop_front();
                if (m_axis_tdata[7:0] !== want.value || m_axis_tdata[9:8] !== want.chan)
                    note_failure($sformatf(
                        "Sample mismatch: expected ch %0d value %0d, got ch %0d value %0d",
                        want.chan, $signed(want.value),
                        m_axis_tdata[9:8], $signed(m_axis_tdata[7:0])));
            end
        end
    end

    // Watchdog: any run of cycles with no beat on either side longer than the
    // limit means the block has hung.
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("FAILURE");
        $finish;
    end

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin : stimulus
        int c;
        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_addr    <= '0;
        i_cfg_wdata   <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= '0;
        // The frame model starts as the block comes out of reset.
        for (c = 0; c < NUM_CH; c++) begin
            fill_pos[c] = '0;
            held_amp[c] = '0;
        end
        cfg_frame_len = FRAME_LEN_RST;
        cfg_out_en    = OUTPUT_EN_RST;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_defaults();
        test_output_disabled();
        test_frame_len_limits();
        // Random phases: mostly short frames, one at the full buffer size, one
        // with output disabled and one without any idling.
        test_random_frames(110, $urandom_range(2, 64), 1'b1, 1'b0);
        test_random_frames(90, $urandom_range(1, 16), 1'b1, 1'b1);
        test_random_frames(70, $urandom_range(65, 300), 1'b0, 1'b0);
        test_random_frames(60, FRAME_MAX, 1'b1, 1'b0);
        test_random_frames(90, $urandom_range(2, 48), 1'b1, 1'b0);
        test_read_backpressure();
        test_random_frames(70, $urandom_range(8, 128), 1'b1, 1'b0);

        // Drain: every read answer, then time for any late or extra beat.
        s_axis_tvalid <= 1'b0;
        while (pending_reads.size() != 0) @(posedge i_clk);
        repeat (settle_cycles()) @(posedge i_clk);
        if (mismatch_count == 0 && pending_reads.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ----- filelist.f -----
src/tdfr_pkg.sv
src/tdfr_ctrl.sv
src/tdfr_datapath.sv
src/timed_dac_frame_renderer_unit.sv
tb/tb_timed_dac_frame_renderer_unit.sv
